>>> rtl/tlt_pkg.sv
// Package: shared types and constants for the timestamp LRU tag table.
package tlt_pkg;

  localparam int SLOT_BITS = 4;

  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic stamp_we;
  } tlt_mem_ctl_t;

endpackage

>>> rtl/tlt_mem.sv
// Key and stamp memories: one write port, one registered read port, shared address per side.
module tlt_mem #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int STAMP_BITS = 32,
  parameter int IDX_W      = 4
) (
  input  logic                   clk,
  input  tlt_pkg::tlt_mem_ctl_t  ctl,
  input  logic [IDX_W-1:0]       rd_addr,
  input  logic [IDX_W-1:0]       wr_addr,
  input  logic [KEY_BITS-1:0]    wr_key,
  input  logic [STAMP_BITS-1:0]  wr_stamp,
  output logic [KEY_BITS-1:0]    rd_key,
  output logic [STAMP_BITS-1:0]  rd_stamp
);
  import tlt_pkg::*;

  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (ctl.rd_en) begin
      rd_key <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (ctl.rd_en) begin
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

>>> rtl/tlt_ctrl.sv
// Sequencer: valid bits, request counter, key search and LRU victim scan over the memories.
module tlt_ctrl #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int STAMP_BITS = 32,
  parameter int IDX_W      = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [KEY_BITS-1:0]    key,
  output logic                   res_valid,
  input  logic                   res_take,
  output logic                   res_hit,
  output logic [IDX_W-1:0]       res_slot,
  output logic                   res_evicted,
  output tlt_pkg::tlt_mem_ctl_t  mem_ctl,
  output logic [IDX_W-1:0]       rd_addr,
  output logic [IDX_W-1:0]       wr_addr,
  output logic [KEY_BITS-1:0]    wr_key,
  output logic [STAMP_BITS-1:0]  wr_stamp,
  input  logic [KEY_BITS-1:0]    rd_key,
  input  logic [STAMP_BITS-1:0]  rd_stamp
);
  import tlt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [1:0]            state;
  logic                  mode_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [ENTRIES-1:0]    valid_vec;
  logic [STAMP_BITS-1:0] counter;
  logic [IDX_W-1:0]      rd_idx;
  logic                  iss;
  logic                  chk;
  logic [IDX_W-1:0]      chk_idx;
  logic                  found;
  logic [IDX_W-1:0]      found_idx;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [IDX_W-1:0]      best_idx;
  logic                  evict_q;

  logic                  accept;
  logic                  any_free;
  logic [IDX_W-1:0]      free_idx;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_vec[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    mem_ctl.rd_en    = (state == ST_SCAN) && iss;
    mem_ctl.key_we   = (state == ST_WRITE) && mode_q;
    mem_ctl.stamp_we = (state == ST_WRITE) && (mode_q || found);
    rd_addr          = rd_idx;
    wr_addr          = mode_q ? best_idx : found_idx;
    wr_key           = key_q;
    wr_stamp         = counter;
  end

  assign res_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid_vec <= '0;
      counter   <= '0;
      iss       <= 1'b0;
      chk       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_q  <= mode;
            key_q   <= key;
            found   <= 1'b0;
            rd_idx  <= '0;
            evict_q <= 1'b0;
            if (!mode) begin
              if (counter != '1) begin
                counter <= counter + 1'b1;
              end
              iss   <= 1'b1;
              state <= ST_SCAN;
            end else if (any_free) begin
              best_idx <= free_idx;
              state    <= ST_WRITE;
            end else begin
              evict_q <= 1'b1;
              iss     <= 1'b1;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          chk     <= iss;
          chk_idx <= rd_idx;
          if (iss) begin
            if (rd_idx == LAST_IDX) begin
              iss <= 1'b0;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
          if (chk) begin
            if (!mode_q) begin
              if (valid_vec[chk_idx] && rd_key == key_q) begin
                found     <= 1'b1;
                found_idx <= chk_idx;
              end
            end else if (chk_idx == '0 || rd_stamp < best_stamp) begin
              best_stamp <= rd_stamp;
              best_idx   <= chk_idx;
            end
            if (chk_idx == LAST_IDX) begin
              state <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          chk         <= 1'b0;
          res_hit     <= !mode_q && found;
          res_slot    <= mode_q ? best_idx : (found ? found_idx : '0);
          res_evicted <= mode_q && evict_q;
          if (mode_q) begin
            valid_vec[best_idx] <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/timestamp_lru_tag_table.sv
// Top level: fully associative tag table with timestamp LRU, sequencer, memories, output register.
//
// Input channel (in_valid/in_stall, fields mode and key): mode 0 is a lookup,
// mode 1 an insert issued after a lookup missed. Output channel
// (out_valid/out_stall, fields hit, slot, evicted): one result per item, in order.
// A lookup, or an insert into a full table, walks the key and stamp memories one
// entry per cycle through their registered read port (ST_SCAN), then passes ST_WRITE
// and ST_DONE before out_valid rises from the output register. An insert into a
// table with a free slot goes straight from ST_IDLE to ST_WRITE. The next input
// transfer can happen once the result has moved into the output register.
// in_stall is high from the cycle after an input transfer until the result has
// been handed to the output register. While out_stall is high the result holds;
// a finished result waits in the sequencer until the output register is free.
// Reset (rst, synchronous) empties the table, clears the request counter and
// drops out_valid; the memories need no clearing pass.
module timestamp_lru_tag_table #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [KEY_BITS-1:0]            key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [tlt_pkg::SLOT_BITS-1:0]  slot,
  output logic                           evicted
);
  import tlt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  tlt_mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [STAMP_BITS-1:0] wr_stamp;
  logic [KEY_BITS-1:0]   rd_key;
  logic [STAMP_BITS-1:0] rd_stamp;

  logic                  res_valid;
  logic                  res_take;
  logic                  res_hit;
  logic [IDX_W-1:0]      res_slot;
  logic                  res_evicted;
  logic [IDX_W+SLOT_BITS-1:0] slot_ext;

  tlt_ctrl #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .STAMP_BITS (STAMP_BITS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .key         (key),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res_hit     (res_hit),
    .res_slot    (res_slot),
    .res_evicted (res_evicted),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_key      (wr_key),
    .wr_stamp    (wr_stamp),
    .rd_key      (rd_key),
    .rd_stamp    (rd_stamp)
  );

  tlt_mem #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .STAMP_BITS (STAMP_BITS),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_stamp (wr_stamp),
    .rd_key   (rd_key),
    .rd_stamp (rd_stamp)
  );

  assign res_take = res_valid && (!out_valid || !out_stall);
  assign slot_ext = {{SLOT_BITS{1'b0}}, res_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      hit     <= res_hit;
      slot    <= slot_ext[SLOT_BITS-1:0];
      evicted <= res_evicted;
    end
  end

endmodule

>>> rtl/tlt_checker.sv
// Port-level checker for the timestamp LRU tag table, bound to the top level.
module tlt_checker #(
  parameter int ENTRIES = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           hit,
  input logic [tlt_pkg::SLOT_BITS-1:0]  slot,
  input logic                           evicted
);
  import tlt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(slot) && $stable(evicted))
    else $error("stalled result changed");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("result shows both hit and evicted");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ENTRIES >= (1 << SLOT_BITS)) || (slot < ENTRIES))
    else $error("slot outside the table");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind timestamp_lru_tag_table tlt_checker #(.ENTRIES(ENTRIES)) u_tlt_checker (.*);
